[hdl/sirt_pkg.sv]
// shared types and constants for the signed integer to radix text converter
// used by sirt_digit_div and signed_integer_to_radix_text; no dependencies
package sirt_pkg;

    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [CHAR_W-1:0]  MINUS_CODE = 7'h2D;
    localparam logic [CHAR_W-1:0]  ERROR_CODE = 7'h00;

    localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MINUS,
        ST_READ,
        ST_SEND,
        ST_BAD
    } sirt_state_t;

    typedef struct packed {
        logic               digit_valid;
        logic               final_digit;
        logic [DIGIT_W-1:0] digit;
    } sirt_div_status_t;

endpackage

[hdl/signed_integer_to_radix_text.sv]
// signed integer to radix text converter, top level
// depends on sirt_pkg and sirt_digit_div
//
// channel  dir  handshake                      contents
// s_axis   in   s_axis_tvalid / s_axis_tready  value, radix
// m_axis   out  m_axis_tvalid / m_axis_tready  char_code, last_char (tlast), bad_radix (tuser)
//
// digits come out of the bit-serial divider; each digit then passes through the digit store
// read register and the output register, and a minus sign goes straight to the output register
// one value is converted at a time; s_axis_tready is high only when idle
// a stalled m_axis holds the current word and pauses character output
// aresetn is synchronous and active low; the digit store needs no clearing
module signed_integer_to_radix_text #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // value, radix
    input  logic [((VALUE_WIDTH+sirt_pkg::RADIX_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // char_code
    output logic [7:0]                            m_axis_tdata,
    output logic                                  m_axis_tlast,
    // bad_radix
    output logic                                  m_axis_tuser
);
    import sirt_pkg::*;

    localparam int ND_W = $clog2(VALUE_WIDTH + 1);
    localparam int AW   = $clog2(VALUE_WIDTH);

    sirt_state_t state_reg, state_next;

    logic [ND_W-1:0]    nd_reg, nd_next;
    logic               neg_reg, neg_next;
    logic [DIGIT_W-1:0] rd_data_reg;
    logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
    logic               rd_en;

    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;
    logic               m_bad_reg, m_bad_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [RADIX_W-1:0]     in_radix;
    logic [RADIX_W-1:0]     radix_sat;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   s_acc;
    logic                   slot_free;
    logic                   div_start;
    sirt_div_status_t       div_st;

    assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_radix  = s_axis_tdata[VALUE_WIDTH+RADIX_W-1:VALUE_WIDTH];
    assign radix_sat = (in_radix > RADIX_MAX) ? RADIX_MAX : in_radix;
    // most negative value wraps to its own unsigned magnitude
    assign magnitude = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;

    sirt_digit_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (magnitude),
        .radix    (radix_sat),
        .status   (div_st)
    );

    always_comb begin
        state_next   = state_reg;
        nd_next      = nd_reg;
        neg_next     = neg_reg;
        div_start    = 1'b0;
        rd_en        = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_bad_next   = m_bad_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (in_radix < RADIX_MIN) begin
                        state_next = ST_BAD;
                    end else begin
                        div_start  = 1'b1;
                        neg_next   = in_value[VALUE_WIDTH-1];
                        nd_next    = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_st.digit_valid) begin
                    nd_next = nd_reg + 1'b1;
                    if (div_st.final_digit) begin
                        state_next = neg_reg ? ST_MINUS : ST_READ;
                    end
                end
            end
            ST_MINUS: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = MINUS_CODE;
                    m_last_next  = 1'b0;
                    m_bad_next   = 1'b0;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                // digits come back out of the store most significant first
                rd_en      = 1'b1;
                nd_next    = nd_reg - 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = DIGIT_CHARS[rd_data_reg];
                    m_last_next  = (nd_reg == '0);
                    m_bad_next   = 1'b0;
                    state_next   = (nd_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_BAD: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ERROR_CODE;
                    m_last_next  = 1'b1;
                    m_bad_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nd_reg      <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            nd_reg      <= nd_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
    end

    // digit store, least significant digit at the lowest address
    always_ff @(posedge aclk) begin
        if (div_st.digit_valid) begin
            mem[nd_reg[AW-1:0]] <= div_st.digit;
        end
        if (rd_en) begin
            rd_data_reg <= mem[nd_next[AW-1:0]];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_bad_reg;

    a_bad_radix_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (in_radix < RADIX_MIN)) |=> (state_reg == ST_BAD))
        else $error("bad radix did not take the error path");

    a_digit_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.digit_valid |-> (state_reg == ST_DIV))
        else $error("divider produced a digit outside the divide phase");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nd_reg <= ND_W'(VALUE_WIDTH))
        else $error("digit count ran past the store depth");

    a_last_empties_store: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SEND) && slot_free && (nd_reg == '0)) |=>
            (m_axis_tlast && (state_reg == ST_IDLE)))
        else $error("final digit not marked last");

endmodule

[hdl/sirt_digit_div.sv]
// bit-serial restoring divider: peels off one radix digit per pass over the quotient bits,
// least significant digit first, and reruns on its own quotient until it is zero
// depends on sirt_pkg
module sirt_digit_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [VALUE_WIDTH-1:0]        dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]  radix,
    output sirt_pkg::sirt_div_status_t    status
);
    import sirt_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   nz_reg, nz_next;

    logic [RADIX_W-1:0]     trial;
    logic [RADIX_W-1:0]     diff;
    logic                   ge;

    always_comb begin
        trial      = {rem_reg, quot_reg[VALUE_WIDTH-1]};
        ge         = (trial >= radix_reg);
        diff       = trial - radix_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        radix_next = radix_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        nz_next    = nz_reg;
        status     = '0;
        if (run_reg) begin
            quot_next = {quot_reg[VALUE_WIDTH-2:0], ge};
            rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            nz_next   = nz_reg | ge;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                status.digit_valid = 1'b1;
                status.final_digit = !nz_next;
                status.digit       = rem_next;
                // quotient not yet zero: go round again on it
                cnt_next = '0;
                rem_next = '0;
                nz_next  = 1'b0;
                run_next = (nz_reg | ge);
            end
        end
        if (start) begin
            quot_next  = dividend;
            rem_next   = '0;
            radix_next = radix;
            cnt_next   = '0;
            nz_next    = 1'b0;
            run_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg  <= quot_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            nz_reg  <= 1'b0;
        end else begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            nz_reg  <= nz_next;
        end
    end

endmodule

[tb/tb_top.sv]
// testbench for signed_integer_to_radix_text: streams value/radix words in and checks every
// character word against a behavioural model of the conversion kept in this file
// depends on sirt_pkg and the signed_integer_to_radix_text rtl
`timescale 1ns / 100ps

module tb_top;

    import sirt_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int S_DATA_W    = ((VALUE_W + RADIX_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 150;

    // value in the low bits, radix above it
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] value;
    } conv_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              bad;
    } text_char_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tuser;

    conv_req_t  pending_reqs[$];
    text_char_t text_due[$];
    int         reqs_queued = 0;
    int         reqs_taken = 0;
    int         errors = 0;
    int         cycles = 0;
    int         send_idle_pct = 23;
    int         recv_idle_pct = 61;
    logic       word_taken = 1'b0;

    signed_integer_to_radix_text #(
        .VALUE_WIDTH(VALUE_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // works out the characters a value/radix word should produce
    function automatic void predict_text(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] mag;
        int unsigned        base;
        int unsigned        d;
        logic [CHAR_W-1:0]  digits[$];
        text_char_t         ch;
        if (radix < RADIX_MIN) begin
            ch = '{code: ERROR_CODE, last: 1'b1, bad: 1'b1};
            text_due.push_back(ch);
            return;
        end
        base = (radix > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(radix);
        // two's complement negate also gives the right magnitude for the most negative value
        mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do begin
            d = mag % base;
            mag = mag / base;
            digits.push_front(d < 10 ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h41 + d - 10));
        end while (mag != 0);
        if (value[VALUE_W-1]) begin
            ch = '{code: MINUS_CODE, last: 1'b0, bad: 1'b0};
            text_due.push_back(ch);
        end
        foreach (digits[i]) begin
            ch = '{code: digits[i], last: (i == digits.size() - 1), bad: 1'b0};
            text_due.push_back(ch);
        end
    endfunction

    task automatic queue_req(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix);
        pending_reqs.push_back('{value: value, radix: radix});
        reqs_queued++;
    endtask

    task automatic queue_random(int n);
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        int                 pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 80)
                radix = RADIX_W'($urandom_range(16, 2));
            else if (pick < 90)
                radix = RADIX_W'($urandom_range(1, 0));
            else
                radix = RADIX_W'($urandom_range(31, 17));
            pick = $urandom_range(99);
            if (pick < 50) begin
                value = $urandom;
            end else if (pick < 75) begin
                value = VALUE_W'($urandom_range(1000));
                if ($urandom_range(1))
                    value = -value;
            end else begin
                case ($urandom_range(5))
                    0: value = '0;
                    1: value = VALUE_W'(1);
                    2: value = '1;
                    3: value = {1'b1, {(VALUE_W-1){1'b0}}};
                    4: value = {1'b0, {(VALUE_W-1){1'b1}}};
                    default: value = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
                endcase
            end
            queue_req(value, radix);
        end
    endtask

    task automatic wait_drained();
        while (reqs_taken != reqs_queued || text_due.size() != 0)
            @(posedge aclk);
    endtask

    // sender: holds a word until taken, then offers the next one or idles
    always @(negedge aclk) begin
        if (!s_axis_tvalid || word_taken) begin
            if (aresetn && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata  <= S_DATA_W'(pending_reqs.pop_front());
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // request side: predict on every accepted word
    always @(posedge aclk) begin
        word_taken <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            predict_text(s_axis_tdata[VALUE_W-1:0], s_axis_tdata[VALUE_W +: RADIX_W]);
            reqs_taken <= reqs_taken + 1;
        end
    end

    // result side: compare each character word with the oldest expectation
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (text_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, actual tdata %h last %b user %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = text_due.pop_front();
                if (m_axis_tdata !== {1'b0, want.code}) begin
                    errors++;
                    $display("%0t: char_code mismatch: expected %h, actual %h",
                             $time, {1'b0, want.code}, m_axis_tdata);
                end
                if (m_axis_tlast !== want.last) begin
                    errors++;
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, want.last, m_axis_tlast);
                end
                if (m_axis_tuser !== want.bad) begin
                    errors++;
                    $display("%0t: bad_radix mismatch: expected %b, actual %b",
                             $time, want.bad, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero, extremes, every radix class, letters, saturation and bad radix
        queue_req(32'd0, 5'd10);
        queue_req(32'd0, 5'd2);
        queue_req(32'h7FFF_FFFF, 5'd2);
        queue_req(32'h8000_0000, 5'd2);
        queue_req(32'h8000_0000, 5'd16);
        queue_req(32'h8000_0000, 5'd10);
        queue_req(32'hFFFF_FFFF, 5'd16);
        queue_req(32'hFFFF_FFFF, 5'd2);
        queue_req(32'h7FFF_FFFF, 5'd16);
        queue_req(32'hDEAD_BEEF, 5'd16);
        queue_req(32'h0123_4567, 5'd16);
        queue_req(32'd1, 5'd2);
        queue_req(32'd15, 5'd16);
        queue_req(32'd255, 5'd15);
        queue_req(-32'sd12345, 5'd10);
        queue_req(32'd12345, 5'd3);
        queue_req(32'd823543, 5'd7);
        queue_req(32'hABCD_EF01, 5'd0);
        queue_req(32'h5432_10FE, 5'd1);
        queue_req(32'hCAFE_F00D, 5'd17);
        queue_req(32'h0000_FFFF, 5'd31);
        queue_req(32'd0, 5'd0);
        queue_req(-32'sd1, 5'd11);
        queue_req(32'd1000, 5'd13);

        // sender holds off here until the block has emitted every outstanding character
        wait_drained();
        queue_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 23;
        queue_random(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && text_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[signed_integer_to_radix_text.f]
hdl/sirt_pkg.sv
hdl/sirt_digit_div.sv
hdl/signed_integer_to_radix_text.sv
tb/tb_top.sv
